### sv/rde_pkg.sv
// ----------------------------------------------------------------------------
// rde_pkg
// Shared types and codes for the reversible deque engine: beat payloads,
// operation and status codes, and the control/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package rde_pkg;

	localparam int OP_W   = 3;
	localparam int ELEM_W = 16;
	localparam int STAT_W = 2;

	localparam logic [OP_W-1:0] OP_CLEAR   = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH    = 3'd1;
	localparam logic [OP_W-1:0] OP_REVERSE = 3'd2;
	localparam logic [OP_W-1:0] OP_DELETE  = 3'd3;
	localparam logic [OP_W-1:0] OP_DUMP    = 3'd4;

	localparam logic [STAT_W-1:0] STAT_VALID = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] STAT_ERROR = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [ELEM_W-1:0] push_value;
	} req_t;

	typedef struct packed {
		logic [ELEM_W-1:0] element_value;
		logic [STAT_W-1:0] dump_status;
		logic              last_of_dump;
	} rsp_t;

	typedef struct packed {
		logic              exec;
		logic [OP_W-1:0]   op;
		logic              dump_init;
		logic              issue;
		logic [STAT_W-1:0] issue_status;
		logic              issue_last;
	} dp_cmd_t;

	typedef struct packed {
		logic err;
		logic empty;
		logic can_issue;
		logic idx_last;
	} dp_status_t;

endpackage

### sv/rde_ctrl.sv
// ----------------------------------------------------------------------------
// rde_ctrl
// Controller for the reversible deque engine. Accepts one operation at a time,
// hands plain operations to the datapath and sequences the beats of a dump.
// ----------------------------------------------------------------------------
module rde_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  logic [rde_pkg::OP_W-1:0]     req_op,
	input  rde_pkg::dp_status_t          st,
	output rde_pkg::dp_cmd_t             cmd
);
	import rde_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_DUMP = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;

	assign req_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d          = state_q;
		cmd.exec         = 1'b0;
		cmd.op           = req_op;
		cmd.dump_init    = 1'b0;
		cmd.issue        = 1'b0;
		cmd.issue_status = STAT_VALID;
		cmd.issue_last   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					if (req_op == OP_DUMP) begin
						cmd.dump_init = 1'b1;
						state_d       = ST_DUMP;
					end else begin
						cmd.exec = 1'b1;
					end
				end
			end
			ST_DUMP: begin
				if (st.can_issue) begin
					cmd.issue = 1'b1;
					if (st.err) begin
						cmd.issue_status = STAT_ERROR;
						cmd.issue_last   = 1'b1;
						state_d          = ST_IDLE;
					end else if (st.empty) begin
						cmd.issue_status = STAT_EMPTY;
						cmd.issue_last   = 1'b1;
						state_d          = ST_IDLE;
					end else begin
						cmd.issue_last = st.idx_last;
						if (st.idx_last) begin
							state_d = ST_IDLE;
						end
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTHESIS
	a_issue_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> st.can_issue)
		else $error("beat issued while read stage is blocked");

	a_exec_not_dump: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> (cmd.op != OP_DUMP) && !cmd.issue)
		else $error("dump executed as a plain operation");

	a_dump_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dump_init |=> (state_q == ST_DUMP))
		else $error("dump start did not enter dump sequencing");
`endif

endmodule

### sv/rde_dp.sv
// ----------------------------------------------------------------------------
// rde_dp
// Datapath for the reversible deque engine: ring-buffer store, head pointer,
// element count, reverse and error flags, dump index, registered memory read
// stage and the output register.
// ----------------------------------------------------------------------------
module rde_dp #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [rde_pkg::ELEM_W-1:0]   push_value,
	input  rde_pkg::dp_cmd_t             cmd,
	output rde_pkg::dp_status_t          st,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output rde_pkg::rsp_t                rsp
);
	import rde_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = (DATA_WIDTH < ELEM_W) ? DATA_WIDTH : ELEM_W;
	localparam logic [PW:0]   DEPTH_S = (PW + 1)'(DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	function automatic logic [PW-1:0] wrap_slot(input logic [PW:0] s);
		logic [PW:0] t;
		t = (s >= DEPTH_S) ? (s - DEPTH_S) : s;
		return t[PW-1:0];
	endfunction

	logic [SW-1:0] mem [DEPTH];

	logic [PW-1:0]     head_q;
	logic [CW-1:0]     count_q;
	logic              rev_q;
	logic              err_q;
	logic [PW-1:0]     idx_q;

	logic              rd_v_q;
	logic [STAT_W-1:0] rd_status_q;
	logic              rd_last_q;
	logic [SW-1:0]     rdata_q;

	logic              out_v_q;
	rsp_t              out_q;

	logic              rd_move;
	logic              full;
	logic [CW-1:0]     count_m1;
	logic [CW-1:0]     k_full;
	logic [PW-1:0]     rd_addr;
	logic [PW-1:0]     wr_addr;
	logic [PW-1:0]     head_next;
	logic              wr_en;

	// read stage hands its beat to the output register
	assign rd_move  = rd_v_q && (!out_v_q || !rsp_stall);
	assign full     = (count_q == DEPTH_C);
	assign count_m1 = count_q - CW'(1);
	assign k_full   = rev_q ? (count_m1 - CW'(idx_q)) : CW'(idx_q);

	assign rd_addr   = wrap_slot({1'b0, head_q} + {1'b0, k_full[PW-1:0]});
	assign wr_addr   = wrap_slot({1'b0, head_q} + {1'b0, count_q[PW-1:0]});
	assign head_next = wrap_slot({1'b0, head_q} + (PW + 1)'(1));
	assign wr_en     = cmd.exec && (cmd.op == OP_PUSH) && !full;

	assign st.err       = err_q;
	assign st.empty     = (count_q == '0);
	assign st.can_issue = !rd_v_q || rd_move;
	assign st.idx_last  = (CW'(idx_q) == count_m1);

	assign rsp_valid = out_v_q;
	assign rsp       = out_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= push_value[SW-1:0];
		end
		if (cmd.issue) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			rev_q   <= 1'b0;
			err_q   <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (cmd.exec) begin
				case (cmd.op)
					OP_CLEAR: begin
						head_q  <= '0;
						count_q <= '0;
						rev_q   <= 1'b0;
						err_q   <= 1'b0;
					end
					OP_PUSH: begin
						if (full) begin
							err_q <= 1'b1;
						end else begin
							count_q <= count_q + CW'(1);
						end
					end
					OP_REVERSE: begin
						rev_q <= !rev_q;
					end
					OP_DELETE: begin
						if (count_q == '0) begin
							err_q <= 1'b1;
						end else begin
							if (!rev_q) begin
								head_q <= head_next;
							end
							count_q <= count_m1;
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.dump_init) begin
				idx_q <= '0;
			end else if (cmd.issue) begin
				idx_q <= idx_q + PW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (cmd.issue) begin
				rd_v_q <= 1'b1;
			end else if (rd_move) begin
				rd_v_q <= 1'b0;
			end
			if (rd_move) begin
				out_v_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			rd_status_q <= cmd.issue_status;
			rd_last_q   <= cmd.issue_last;
		end
		if (rd_move) begin
			out_q.element_value <= (rd_status_q == STAT_VALID) ? ELEM_W'(rdata_q) : '0;
			out_q.dump_status   <= rd_status_q;
			out_q.last_of_dump  <= rd_last_q;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("element count beyond depth");

	a_rd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rd_v_q && !rd_move |=> rd_v_q && $stable(rdata_q) && $stable(rd_status_q))
		else $error("read stage lost a blocked beat");

	a_status_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && (out_q.dump_status != STAT_VALID)
		|-> out_q.last_of_dump && (out_q.element_value == '0))
		else $error("status beat not a single zero-valued last beat");
`endif

endmodule

### sv/reversible_deque_engine.sv
// ----------------------------------------------------------------------------
// reversible_deque_engine
// Bounded double-ended queue in a ring buffer with a reverse-order flag.
// ----------------------------------------------------------------------------
// Clear, push, reverse and delete may arrive back to back. A dump holds the
// request side while it issues its result beats: count beats for a populated
// deque, or a single beat when empty or in error. Beats leave through a
// registered store read and an output register; a stalled result side slows
// the dump to the rate at which beats are taken.
module reversible_deque_engine #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  rde_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output rde_pkg::rsp_t rsp
);
	import rde_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t st;

	rde_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_op    (req.operation),
		.st        (st),
		.cmd       (cmd)
	);

	rde_dp #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_value (req.push_value),
		.cmd        (cmd),
		.st         (st),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp)
	);

endmodule
